/* sv/tidg_pkg.sv */
// Shared types, constants and the CRC-16 byte function of the track ID field generator.
// Used by the controller, datapath and top level; depends on nothing.
package tidg_pkg;

  localparam int MAX_SECTORS = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CNT_W-1:0] INTERLEAVE_BASE = 6'd11;
  localparam logic [CNT_W-1:0] SECTOR_LIMIT    = 6'(MAX_SECTORS);

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  SYNC_MARK  = 8'hA1;
  localparam logic [7:0]  ID_MARK    = 8'hFE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTORS_PER_TRACK = 3'd0,
    REG_LENGTH_CODE       = 3'd1,
    REG_SIDES_COUNT       = 3'd2,
    REG_TRACKS_PER_SIDE   = 3'd3,
    REG_INTERLEAVE_ENABLE = 3'd4,
    REG_INTERLEAVE_STEP   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SIDE,
    ST_SECTOR,
    ST_LENGTH,
    ST_EMIT,
    ST_REFUSE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_CRC_TRACK,
    OP_CRC_SIDE,
    OP_CRC_SECTOR,
    OP_CRC_LENGTH,
    OP_EMIT_FIELD,
    OP_EMIT_EMPTY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic refuse;
    logic last_sector;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [7:0] id_track;
    logic       id_side;
    logic [5:0] id_sector;
    logic [1:0] id_length;
    logic [7:0] crc_high;
    logic [7:0] crc_low;
    logic       last_field;
    logic       no_fields;
  } field_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_PRESET =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_MARK), SYNC_MARK), SYNC_MARK), ID_MARK);

endpackage

/* sv/tidg_if.sv */
// Valid/ready channel interfaces for requests and ID fields.
// Depends on nothing.
interface tidg_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_number;
  logic       side_number;

  modport source (output valid, output track_number, output side_number, input ready);
  modport sink   (input valid, input track_number, input side_number, output ready);
endinterface

interface tidg_field_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_track;
  logic       id_side;
  logic [5:0] id_sector;
  logic [1:0] id_length;
  logic [7:0] crc_high;
  logic [7:0] crc_low;
  logic       last_field;
  logic       no_fields;

  modport source (output valid, output id_track, output id_side, output id_sector,
                  output id_length, output crc_high, output crc_low, output last_field,
                  output no_fields, input ready);
  modport sink   (input valid, input id_track, input id_side, input id_sector,
                  input id_length, input crc_high, input crc_low, input last_field,
                  input no_fields, output ready);
endinterface

/* sv/tidg_ctrl.sv */
// Sequencer of the track ID field generator: walks one request through its CRC bytes
// and output loads. Depends on tidg_pkg.
module tidg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tidg_pkg::status_t status,
  output tidg_pkg::cmd_t   cmd
);

  tidg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tidg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = tidg_pkg::OP_NONE;
    req_ready  = 1'b0;
    case (state)
      tidg_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = tidg_pkg::OP_LATCH;
          state_next = tidg_pkg::ST_DECIDE;
        end
      end
      tidg_pkg::ST_DECIDE: begin
        if (status.refuse) begin
          state_next = tidg_pkg::ST_REFUSE;
        end else begin
          cmd.op     = tidg_pkg::OP_CRC_TRACK;
          state_next = tidg_pkg::ST_SIDE;
        end
      end
      tidg_pkg::ST_SIDE: begin
        cmd.op     = tidg_pkg::OP_CRC_SIDE;
        state_next = tidg_pkg::ST_SECTOR;
      end
      tidg_pkg::ST_SECTOR: begin
        cmd.op     = tidg_pkg::OP_CRC_SECTOR;
        state_next = tidg_pkg::ST_LENGTH;
      end
      tidg_pkg::ST_LENGTH: begin
        cmd.op     = tidg_pkg::OP_CRC_LENGTH;
        state_next = tidg_pkg::ST_EMIT;
      end
      tidg_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = tidg_pkg::OP_EMIT_FIELD;
          state_next = status.last_sector ? tidg_pkg::ST_IDLE : tidg_pkg::ST_SECTOR;
        end
      end
      tidg_pkg::ST_REFUSE: begin
        if (status.out_free) begin
          cmd.op     = tidg_pkg::OP_EMIT_EMPTY;
          state_next = tidg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tidg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/tidg_dp.sv */
// Datapath of the track ID field generator: configuration registers, request latch,
// sector numbering, byte-wide CRC-16 unit and output register. Depends on tidg_pkg.
module tidg_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [tidg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tidg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]                       req_track,
  input  logic                             req_side,
  input  tidg_pkg::cmd_t                   cmd,
  output tidg_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output tidg_pkg::field_t                 out_field
);

  logic [5:0] sectors_per_track;
  logic [1:0] length_code;
  logic [1:0] sides_count;
  logic [7:0] tracks_per_side;
  logic       interleave_enable;
  logic [4:0] interleave_step;

  logic [7:0]  track_q;
  logic        side_q;
  logic        refuse_q;
  logic        interleave_q;
  logic [5:0]  count_q;
  logic [4:0]  step_q;
  logic [4:0]  n_q;
  logic [4:0]  acc_q;
  logic [15:0] crc_q;
  logic [15:0] base_q;

  logic [5:0]  count_eff;
  logic        interleave_now;
  logic [4:0]  step_mod;
  logic [5:0]  n_plus;
  logic [5:0]  acc_sum;
  logic [5:0]  sector;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= 6'd9;
      length_code       <= 2'd2;
      sides_count       <= 2'd2;
      tracks_per_side   <= 8'd80;
      interleave_enable <= 1'b0;
      interleave_step   <= 5'd6;
    end else if (cfg_write_en) begin
      case (cfg_index)
        tidg_pkg::REG_SECTORS_PER_TRACK: sectors_per_track <= cfg_wdata[5:0];
        tidg_pkg::REG_LENGTH_CODE:       length_code       <= cfg_wdata[1:0];
        tidg_pkg::REG_SIDES_COUNT:       sides_count       <= cfg_wdata[1:0];
        tidg_pkg::REG_TRACKS_PER_SIDE:   tracks_per_side   <= cfg_wdata[7:0];
        tidg_pkg::REG_INTERLEAVE_ENABLE: interleave_enable <= cfg_wdata[0];
        tidg_pkg::REG_INTERLEAVE_STEP:   interleave_step   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_eff = (sectors_per_track > tidg_pkg::SECTOR_LIMIT) ? tidg_pkg::SECTOR_LIMIT
                                                            : sectors_per_track;
    interleave_now = interleave_enable &&
                     ((count_eff == tidg_pkg::INTERLEAVE_BASE) ||
                      (count_eff == 6'(2 * tidg_pkg::INTERLEAVE_BASE)));
    // count is 11 or 22 whenever the step is used
    if ({1'b0, interleave_step} >= 6'(2 * tidg_pkg::INTERLEAVE_BASE)) begin
      step_mod = 5'({1'b0, interleave_step} - 6'(2 * tidg_pkg::INTERLEAVE_BASE));
    end else if ((count_eff == tidg_pkg::INTERLEAVE_BASE) &&
                 ({1'b0, interleave_step} >= tidg_pkg::INTERLEAVE_BASE)) begin
      step_mod = 5'({1'b0, interleave_step} - tidg_pkg::INTERLEAVE_BASE);
    end else begin
      step_mod = interleave_step;
    end
    n_plus   = {1'b0, n_q} + 6'd1;
    acc_sum  = {1'b0, acc_q} + {1'b0, step_q};
    sector   = interleave_q ? ({1'b0, acc_q} + 6'd1) : n_plus;
    out_free = !out_valid || out_ready;
    status.refuse      = refuse_q;
    status.last_sector = (n_plus == count_q);
    status.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tidg_pkg::OP_LATCH: begin
        track_q      <= req_track;
        side_q       <= req_side;
        count_q      <= count_eff;
        interleave_q <= interleave_now;
        step_q       <= step_mod;
        n_q          <= '0;
        acc_q        <= '0;
        refuse_q     <= ({1'b0, req_side} >= sides_count) || (req_track >= tracks_per_side) ||
                        (count_eff == 6'd0);
      end
      tidg_pkg::OP_CRC_TRACK:  crc_q  <= tidg_pkg::crc_byte(tidg_pkg::CRC_PRESET, track_q);
      tidg_pkg::OP_CRC_SIDE:   base_q <= tidg_pkg::crc_byte(crc_q, {7'd0, side_q});
      tidg_pkg::OP_CRC_SECTOR: crc_q  <= tidg_pkg::crc_byte(base_q, {2'd0, sector});
      tidg_pkg::OP_CRC_LENGTH: crc_q  <= tidg_pkg::crc_byte(crc_q, {6'd0, length_code});
      tidg_pkg::OP_EMIT_FIELD: begin
        n_q   <= n_plus[4:0];
        acc_q <= (acc_sum >= count_q) ? 5'(acc_sum - count_q) : acc_sum[4:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == tidg_pkg::OP_EMIT_FIELD || cmd.op == tidg_pkg::OP_EMIT_EMPTY) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tidg_pkg::OP_EMIT_FIELD) begin
      out_field.id_track   <= track_q;
      out_field.id_side    <= side_q;
      out_field.id_sector  <= sector;
      out_field.id_length  <= length_code;
      out_field.crc_high   <= crc_q[15:8];
      out_field.crc_low    <= crc_q[7:0];
      out_field.last_field <= status.last_sector;
      out_field.no_fields  <= 1'b0;
    end else if (cmd.op == tidg_pkg::OP_EMIT_EMPTY) begin
      out_field.id_track   <= '0;
      out_field.id_side    <= 1'b0;
      out_field.id_sector  <= '0;
      out_field.id_length  <= '0;
      out_field.crc_high   <= '0;
      out_field.crc_low    <= '0;
      out_field.last_field <= 1'b1;
      out_field.no_fields  <= 1'b1;
    end
  end

endmodule

/* sv/track_id_field_generator.sv */
// Track ID field generator: for each track/side request, one sector ID field per
// sector with its CRC-16, or one empty item for a request out of range or with no
// sectors configured. A refused request is latched, decided on, then emitted as its
// item once the output register is free. Otherwise the latch and the header CRC (track,
// side bytes) come first, then each field takes three steps (sector byte, length byte,
// output load); the next request is taken once the last field sits in the output register.
module track_id_field_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [tidg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tidg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tidg_req_if.sink                         req,
  tidg_field_if.source                     fld
);

  tidg_pkg::cmd_t    cmd;
  tidg_pkg::status_t status;
  tidg_pkg::field_t  out_field;

  tidg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tidg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .req_track    (req.track_number),
    .req_side     (req.side_number),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (fld.ready),
    .out_valid    (fld.valid),
    .out_field    (out_field)
  );

  assign fld.id_track   = out_field.id_track;
  assign fld.id_side    = out_field.id_side;
  assign fld.id_sector  = out_field.id_sector;
  assign fld.id_length  = out_field.id_length;
  assign fld.crc_high   = out_field.crc_high;
  assign fld.crc_low    = out_field.crc_low;
  assign fld.last_field = out_field.last_field;
  assign fld.no_fields  = out_field.no_fields;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one in work");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    fld.valid && !fld.no_fields |-> fld.id_sector >= 6'd1 && fld.id_sector <= 6'd32)
    else $error("sector number out of range");

  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    fld.valid && fld.no_fields |-> fld.last_field && fld.id_sector == 6'd0 &&
      fld.crc_high == 8'd0 && fld.crc_low == 8'd0)
    else $error("empty item carries data");

endmodule
